@@ design/framed_container_verifier_top_defines.svh @@
// ----------------------------------------------------------------------------
// framed_container_verifier_top_defines.svh
// Assertion macros used by the verifier's checker.
// ----------------------------------------------------------------------------
`ifndef FRAMED_CONTAINER_VERIFIER_TOP_DEFINES_SVH
`define FRAMED_CONTAINER_VERIFIER_TOP_DEFINES_SVH

// Same-cycle implication, masked while reset is active.
`define FCV_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is active.
`define FCV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also covers reset itself.
`define FCV_ASSERT_RST(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/fcv_pkg.sv @@
// ----------------------------------------------------------------------------
// fcv_pkg
// Types, constants and the FNV-1a step shared by the container verifier.
// ----------------------------------------------------------------------------
`default_nettype none

package fcv_pkg;

    localparam int unsigned POS_W      = 27;
    localparam int unsigned HDR_BYTES  = 28;
    localparam int unsigned QDEPTH     = 4;
    localparam int unsigned QAW        = $clog2(QDEPTH);
    localparam int unsigned OBUF_DEPTH = 2;
    localparam int unsigned OB_AW      = $clog2(OBUF_DEPTH);
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [POS_W-1:0] POS_MAX   = '1;
    localparam logic [63:0]      FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

    // register map
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXSIZE = 2'd2;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_SIZE  = 3'd1,
        ST_BAD_MAGIC = 3'd2,
        ST_BAD_VER   = 3'd3,
        ST_BAD_LEN   = 3'd4,
        ST_BAD_SUM   = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        K_MAGIC   = 3'd0,
        K_VERSION = 3'd1,
        K_LENGTH  = 3'd2,
        K_HASH    = 3'd3,
        K_PAYLOAD = 3'd4
    } t_kind;

    // classified byte, front to back
    typedef struct packed {
        logic [7:0]       data;
        t_kind            kind;
        logic [2:0]       idx;        // byte lane within the header field
        logic             last;
        logic [POS_W-1:0] total;      // byte count including this one
        logic             bad_size;
        logic             magic_bad;
    } t_fe_entry;

    typedef struct packed {
        t_status          status;
        logic [63:0]      hash;
        logic [POS_W-1:0] payload;
    } t_result;

    // one FNV-1a 64 round; prime = 2^40 + 2^8 + 0xB3
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

`default_nettype wire

@@ design/framed_container_verifier_top.sv @@
// ----------------------------------------------------------------------------
// framed_container_verifier_top
// Framed container checker: header fields plus FNV-1a 64 payload checksum.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel: one container byte per transaction (push / full). Mark
//    the final byte with i_last_byte. The first 28 bytes are the header.
//  - Result channel: one verdict per container (empty / pop): status,
//    computed hash and payload byte count. The result stays put until popped.
//  - Config channel: i_cfg_valid / o_cfg_ready, ready is always high.
//    Index 0 magic word, 1 expected version, 2 size limit; others ignored.
//    Write only while no container is in flight.
//  - Throughput: one byte per cycle unless full is high. The front updates
//    position, size limit and magic check at accept; the back's FNV round
//    (shift-add multiply by the prime) retires one byte per unstalled cycle.
//  - Verdict path: the final byte is written to the byte queue, then its
//    verdict to the result buffer, which drives the result ports.
//  - Stall: if results are not popped, the two-entry result buffer and the
//    four-entry byte queue fill, then full rises; nothing is dropped.
//  - Reset (i_rst_n low, synchronous): queues empty, parse state cleared,
//    config back to magic 0, version 2, limit 2^26.
// ----------------------------------------------------------------------------
`default_nettype none

module framed_container_verifier_top import fcv_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // byte input
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [7:0]           i_data_byte,
    input  wire logic                 i_last_byte,
    // verdict output
    output logic                      empty,
    input  wire logic                 pop,
    output logic [2:0]                o_status,
    output logic [63:0]               o_computed_hash,
    output logic [POS_W-1:0]          o_payload_bytes,
    // configuration writes
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [63:0]          i_cfg_data
);

    // configuration registers
    logic [63:0]      r_magic_word;
    logic [31:0]      r_expected_version;
    logic [POS_W-1:0] r_max_total_bytes;

    logic      in_accept;
    logic      q_empty;
    logic      q_pop;
    t_fe_entry fe_entry;
    t_fe_entry q_entry;
    t_result   result;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_word       <= '0;
            r_expected_version <= 32'd2;
            r_max_total_bytes  <= POS_W'(1 << 26);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MAGIC:   r_magic_word       <= i_cfg_data;
                CFG_VERSION: r_expected_version <= i_cfg_data[31:0];
                CFG_MAXSIZE: r_max_total_bytes  <= i_cfg_data[POS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // front: position, size limit, magic, classification
    fcv_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (in_accept),
        .i_data_byte       (i_data_byte),
        .i_last_byte       (i_last_byte),
        .i_magic_word      (r_magic_word),
        .i_max_total_bytes (r_max_total_bytes),
        .o_entry           (fe_entry)
    );

    // decouples the front from back-pressure at the result side
    fcv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_entry (fe_entry),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_entry (q_entry)
    );

    // back: header capture, hash, verdict, result buffer
    fcv_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_empty          (q_empty),
        .i_entry            (q_entry),
        .o_q_pop            (q_pop),
        .i_expected_version (r_expected_version),
        .o_empty            (empty),
        .i_pop              (pop),
        .o_result           (result)
    );

    assign o_status        = result.status;
    assign o_computed_hash = result.hash;
    assign o_payload_bytes = result.payload;

endmodule

`default_nettype wire

@@ design/fcv_front.sv @@
// ----------------------------------------------------------------------------
// fcv_front
// Accepts bytes, tracks position, size limit and magic, classifies each byte.
// ----------------------------------------------------------------------------
`default_nettype none

module fcv_front import fcv_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_last_byte,
    input  wire logic [63:0]       i_magic_word,
    input  wire logic [POS_W-1:0]  i_max_total_bytes,
    output t_fe_entry              o_entry
);

    logic [POS_W-1:0] r_pos;
    logic             r_oversize;
    logic             r_magic_bad;

    logic [POS_W-1:0] n_pos;
    logic             n_oversize;
    logic             n_magic_bad;
    t_kind            kind;
    logic [2:0]       lane;

    always_comb begin
        lane = r_pos[2:0];
        if (r_pos < POS_W'(8)) begin
            kind = K_MAGIC;
        end else if (r_pos < POS_W'(12)) begin
            kind = K_VERSION;
        end else if (r_pos < POS_W'(20)) begin
            kind = K_LENGTH;
        end else if (r_pos < POS_W'(HDR_BYTES)) begin
            kind = K_HASH;
        end else begin
            kind = K_PAYLOAD;
        end

        n_oversize  = r_oversize || (r_pos >= i_max_total_bytes) || (r_pos == POS_MAX);
        n_magic_bad = r_magic_bad ||
                      ((kind == K_MAGIC) && (i_data_byte != i_magic_word[8*lane +: 8]));
        n_pos       = (r_pos == POS_MAX) ? POS_MAX : r_pos + POS_W'(1);

        o_entry.data      = i_data_byte;
        o_entry.kind      = kind;
        // length and checksum start at lane 4 of their 8-byte window
        o_entry.idx       = (kind == K_LENGTH || kind == K_HASH) ? lane - 3'd4 : lane;
        o_entry.last      = i_last_byte;
        o_entry.total     = n_pos;
        o_entry.bad_size  = n_oversize || (n_pos < POS_W'(HDR_BYTES));
        o_entry.magic_bad = n_magic_bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_oversize  <= 1'b0;
            r_magic_bad <= 1'b0;
        end else if (i_accept) begin
            if (i_last_byte) begin
                r_pos       <= '0;
                r_oversize  <= 1'b0;
                r_magic_bad <= 1'b0;
            end else begin
                r_pos       <= n_pos;
                r_oversize  <= n_oversize;
                r_magic_bad <= n_magic_bad;
            end
        end
    end

endmodule

`default_nettype wire

@@ design/fcv_queue.sv @@
// ----------------------------------------------------------------------------
// fcv_queue
// Small flop queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module fcv_queue import fcv_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire t_fe_entry  i_entry,
    output logic            o_full,
    input  wire logic       i_pop,
    output logic            o_empty,
    output t_fe_entry       o_entry
);

    t_fe_entry        r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr_ptr;
    logic [QAW-1:0]   r_rd_ptr;
    logic [QAW:0]     r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QAW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QAW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (QAW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (QAW+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ design/fcv_back.sv @@
// ----------------------------------------------------------------------------
// fcv_back
// Captures header fields, runs the FNV-1a hash, forms the verdict and
// buffers results.
// ----------------------------------------------------------------------------
`default_nettype none

module fcv_back import fcv_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_q_empty,
    input  wire t_fe_entry    i_entry,
    output logic              o_q_pop,
    input  wire logic [31:0]  i_expected_version,
    output logic              o_empty,
    input  wire logic         i_pop,
    output t_result           o_result
);

    logic [31:0] r_version;
    logic [63:0] r_decl_len;
    logic [63:0] r_decl_hash;
    logic [63:0] r_hash;

    logic [31:0] n_version;
    logic [63:0] n_decl_len;
    logic [63:0] n_decl_hash;
    logic [63:0] n_hash;

    t_result           r_ob [OBUF_DEPTH];
    logic [OB_AW-1:0]  r_ob_wr;
    logic [OB_AW-1:0]  r_ob_rd;
    logic [OB_AW:0]    r_ob_cnt;

    logic              fire;
    logic              ob_push;
    logic              ob_pop;
    logic [POS_W-1:0]  payload;
    t_result           res;

    assign fire    = !i_q_empty && (r_ob_cnt != (OB_AW+1)'(OBUF_DEPTH));
    assign o_q_pop = fire;
    assign ob_push = fire && i_entry.last;
    assign ob_pop  = i_pop && !o_empty;
    assign o_empty = (r_ob_cnt == '0);
    assign o_result = r_ob[r_ob_rd];

    always_comb begin
        n_version   = r_version;
        n_decl_len  = r_decl_len;
        n_decl_hash = r_decl_hash;
        n_hash      = r_hash;
        unique case (i_entry.kind)
            K_MAGIC: begin
            end
            K_VERSION: begin
                n_version[8*i_entry.idx[1:0] +: 8] =
                    r_version[8*i_entry.idx[1:0] +: 8] | i_entry.data;
            end
            K_LENGTH: begin
                n_decl_len[8*i_entry.idx +: 8] = r_decl_len[8*i_entry.idx +: 8] | i_entry.data;
            end
            K_HASH: begin
                n_decl_hash[8*i_entry.idx +: 8] =
                    r_decl_hash[8*i_entry.idx +: 8] | i_entry.data;
            end
            K_PAYLOAD: begin
                n_hash = fnv_step(r_hash, i_entry.data);
            end
            default: begin
            end
        endcase

        payload = (i_entry.total >= POS_W'(HDR_BYTES)) ?
                  i_entry.total - POS_W'(HDR_BYTES) : '0;

        res.hash    = n_hash;
        res.payload = payload;
        priority if (i_entry.bad_size) begin
            res.status = ST_BAD_SIZE;
        end else if (i_entry.magic_bad) begin
            res.status = ST_BAD_MAGIC;
        end else if (n_version != i_expected_version) begin
            res.status = ST_BAD_VER;
        end else if (n_decl_len != {{(64-POS_W){1'b0}}, payload}) begin
            res.status = ST_BAD_LEN;
        end else if (n_hash != n_decl_hash) begin
            res.status = ST_BAD_SUM;
        end else begin
            res.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version   <= '0;
            r_decl_len  <= '0;
            r_decl_hash <= '0;
            r_hash      <= FNV_BASIS;
        end else if (fire) begin
            if (i_entry.last) begin
                r_version   <= '0;
                r_decl_len  <= '0;
                r_decl_hash <= '0;
                r_hash      <= FNV_BASIS;
            end else begin
                r_version   <= n_version;
                r_decl_len  <= n_decl_len;
                r_decl_hash <= n_decl_hash;
                r_hash      <= n_hash;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ob_push) begin
            r_ob[r_ob_wr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_wr  <= '0;
            r_ob_rd  <= '0;
            r_ob_cnt <= '0;
        end else begin
            if (ob_push) begin
                r_ob_wr <= r_ob_wr + OB_AW'(1);
            end
            if (ob_pop) begin
                r_ob_rd <= r_ob_rd + OB_AW'(1);
            end
            if (ob_push && !ob_pop) begin
                r_ob_cnt <= r_ob_cnt + (OB_AW+1)'(1);
            end else if (ob_pop && !ob_push) begin
                r_ob_cnt <= r_ob_cnt - (OB_AW+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ design/fcv_checker.sv @@
// ----------------------------------------------------------------------------
// fcv_checker
// Port-level checks on the container verifier, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "framed_container_verifier_top_defines.svh"

module fcv_checker import fcv_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             empty,
    input  wire logic             pop,
    input  wire logic [2:0]       o_status,
    input  wire logic [63:0]      o_computed_hash,
    input  wire logic [POS_W-1:0] o_payload_bytes
);

    `FCV_ASSERT_RST(a_rst_empty, i_clk, !i_rst_n, empty, "result pending after reset")

    `FCV_ASSERT_IMPL(a_status_range, i_clk, i_rst_n, !empty,
        (o_status == ST_OK) || (o_status == ST_BAD_SIZE) || (o_status == ST_BAD_MAGIC) ||
        (o_status == ST_BAD_VER) || (o_status == ST_BAD_LEN) || (o_status == ST_BAD_SUM),
        "status code out of range")

    `FCV_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !empty && !pop,
        !empty && $stable(o_status) && $stable(o_computed_hash) && $stable(o_payload_bytes),
        "stalled result changed")

    `FCV_ASSERT_IMPL(a_empty_payload, i_clk, i_rst_n, !empty && (o_payload_bytes == '0),
        o_computed_hash == FNV_BASIS, "hash moved without payload bytes")

endmodule

bind framed_container_verifier_top fcv_checker u_fcv_checker (.*);

`default_nettype wire

@@ tb/framed_container_verifier_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_container_verifier_top_tb
// Streams framed containers through the verifier one byte per transaction.
// Well-formed, damaged, short and oversized containers are sent under several
// register settings. A local tracker of the header parse and the FNV-1a 64
// payload hash predicts each verdict. Every popped verdict is compared with it.
// ----------------------------------------------------------------------------
module framed_container_verifier_top_tb;
    import fcv_pkg::*;

    localparam logic [63:0]          FNV_PRIME      = 64'd1099511628211;
    localparam logic [POS_W-1:0]     SIZE_LIMIT_TOP = 27'd67108864;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED   = 2'd3;  // index with no register
    localparam int unsigned          WATCHDOG_LIMIT = 3000;
    localparam int unsigned          HOLDOFF_CYCLES = 300;
    localparam int unsigned          SETTLE_CYCLES  = 6;     // verdict latency plus margin

    // How a generated container is damaged.
    typedef enum int {
        DEFECT_NONE,
        DEFECT_MAGIC,
        DEFECT_VERSION,
        DEFECT_LENGTH,
        DEFECT_CHECKSUM,
        DEFECT_TRUNCATE
    } t_defect;

    // Receiver pop rate while it is not held off.
    typedef enum int {
        PACE_STEADY,
        PACE_HALF,
        PACE_SPARSE
    } t_rx_pace;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_stream_byte;

    // ------------------------------------------------------------------------
    // DUT signals. Every input has a known value from time zero.
    // ------------------------------------------------------------------------
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 push        = 1'b0;
    logic                 full;
    logic [7:0]           i_data_byte = '0;
    logic                 i_last_byte = 1'b0;
    logic                 empty;
    logic                 pop         = 1'b0;
    logic [2:0]           o_status;
    logic [63:0]          o_computed_hash;
    logic [POS_W-1:0]     o_payload_bytes;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [63:0]          i_cfg_data  = '0;

    framed_container_verifier_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .empty           (empty),
        .pop             (pop),
        .o_status        (o_status),
        .o_computed_hash (o_computed_hash),
        .o_payload_bytes (o_payload_bytes),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Local copy of the registers and of the parse state, in lockstep with
    // the block: registers change on a config transaction, parse state on
    // every accepted byte.
    // ------------------------------------------------------------------------
    logic [63:0]      exp_magic;
    logic [31:0]      exp_version;
    logic [POS_W-1:0] exp_size_limit;

    logic [POS_W-1:0] pos_count;       // bytes of this container so far, saturating
    logic             magic_mismatch;
    logic [31:0]      hdr_version;
    logic [63:0]      hdr_length;
    logic [63:0]      hdr_checksum;
    logic [63:0]      payload_hash;
    logic             size_exceeded;

    // Stimulus bookkeeping shared between the processes.
    t_stream_byte pending_bytes[$];    // bytes still to be offered by the driver
    t_result      pending_verdicts[$]; // predicted verdicts not yet popped
    logic [7:0]   frame_bytes[$];      // scratch for the container being built
    bit           byte_taken      = 1'b0;
    bit           holdoff_request = 1'b0;

    int unsigned bytes_queued       = 0;
    int unsigned containers_queued  = 0;
    int unsigned verdicts_checked   = 0;
    int unsigned mismatch_count     = 0;
    int unsigned backpressure_cycles = 0;
    int unsigned idle_cycles        = 0;
    int unsigned verdict_tally [0:5] = '{default: 0};

    function automatic logic [63:0] fnv1a_round(input logic [63:0] h, input logic [7:0] b);
        return (h ^ {56'd0, b}) * FNV_PRIME;
    endfunction

    function automatic void clear_tracking();
        pos_count      = '0;
        magic_mismatch = 1'b0;
        hdr_version    = '0;
        hdr_length     = '0;
        hdr_checksum   = '0;
        payload_hash   = FNV_BASIS;
        size_exceeded  = 1'b0;
    endfunction

    // Fold one accepted byte into the parse state. Returns 1 with the verdict
    // when the byte closes a container.
    function automatic bit track_container_byte(input logic [7:0] value, input logic is_last,
                                                output t_result verdict);
        logic [POS_W-1:0] total;
        logic [POS_W-1:0] payload;
        int unsigned      lane;
        verdict = '0;
        // limit is checked per byte, before the byte is counted
        if (pos_count >= exp_size_limit || pos_count == POS_MAX)
            size_exceeded = 1'b1;
        if (pos_count < 8) begin
            lane = pos_count;
            if (value != exp_magic[8*lane +: 8])
                magic_mismatch = 1'b1;
        end else if (pos_count < 12) begin
            lane = pos_count - 8;
            hdr_version |= 32'(value) << (8 * lane);
        end else if (pos_count < 20) begin
            lane = pos_count - 12;
            hdr_length |= 64'(value) << (8 * lane);
        end else if (pos_count < HDR_BYTES) begin
            lane = pos_count - 20;
            hdr_checksum |= 64'(value) << (8 * lane);
        end else begin
            payload_hash = fnv1a_round(payload_hash, value);
        end
        total     = (pos_count == POS_MAX) ? POS_MAX : pos_count + 1'b1;
        pos_count = total;
        if (!is_last)
            return 1'b0;

        payload = (total >= HDR_BYTES) ? total - POS_W'(HDR_BYTES) : '0;
        if (total < HDR_BYTES || size_exceeded)
            verdict.status = ST_BAD_SIZE;
        else if (magic_mismatch)
            verdict.status = ST_BAD_MAGIC;
        else if (hdr_version != exp_version)
            verdict.status = ST_BAD_VER;
        else if (hdr_length != 64'(payload))
            verdict.status = ST_BAD_LEN;
        else if (payload_hash != hdr_checksum)
            verdict.status = ST_BAD_SUM;
        else
            verdict.status = ST_OK;
        verdict.hash    = payload_hash;
        verdict.payload = payload;
        clear_tracking();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers. Containers are built in frame_bytes and then appended
    // to the driver's queue; the final byte carries the last flag.
    // ------------------------------------------------------------------------
    task automatic send_frame();
        foreach (frame_bytes[i])
            pending_bytes.insert(pending_bytes.size(),
                                 '{data: frame_bytes[i],
                                   last: (i == frame_bytes.size() - 1)});
        bytes_queued      += frame_bytes.size();
        containers_queued += 1;
        frame_bytes.delete();
    endtask

    task automatic queue_noise(input int unsigned count);
        repeat (count) frame_bytes.insert(frame_bytes.size(), 8'($urandom));
        send_frame();
    endtask

    task automatic queue_container(input logic [63:0] magic, input logic [31:0] version,
                                   input int unsigned payload_len, input t_defect flaw);
        logic [7:0]  body[$];
        logic [63:0] length_field;
        logic [63:0] checksum;
        int unsigned keep;
        checksum = FNV_BASIS;
        for (int i = 0; i < payload_len; i++) begin
            body.insert(body.size(), 8'($urandom));
            checksum = fnv1a_round(checksum, body[i]);
        end
        length_field = 64'(payload_len);
        // single bit flips keep the damage minimal and hit every lane over time
        case (flaw)
            DEFECT_MAGIC:    magic        ^= 64'd1 << $urandom_range(63, 0);
            DEFECT_VERSION:  version      ^= 32'd1 << $urandom_range(31, 0);
            DEFECT_LENGTH:   length_field ^= 64'd1 << $urandom_range(63, 0);
            DEFECT_CHECKSUM: checksum     ^= 64'd1 << $urandom_range(63, 0);
            default: ;
        endcase
        for (int i = 0; i < 8; i++) frame_bytes.insert(frame_bytes.size(), magic[8*i +: 8]);
        for (int i = 0; i < 4; i++) frame_bytes.insert(frame_bytes.size(), version[8*i +: 8]);
        for (int i = 0; i < 8; i++)
            frame_bytes.insert(frame_bytes.size(), length_field[8*i +: 8]);
        for (int i = 0; i < 8; i++)
            frame_bytes.insert(frame_bytes.size(), checksum[8*i +: 8]);
        foreach (body[i]) frame_bytes.insert(frame_bytes.size(), body[i]);
        if (flaw == DEFECT_TRUNCATE) begin
            keep = $urandom_range(frame_bytes.size() - 1, 1);
            while (frame_bytes.size() > keep) frame_bytes.delete(frame_bytes.size() - 1);
        end
        send_frame();
    endtask

    // One config transaction; the local register copy follows at the handshake.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index, input logic [63:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (index)
            CFG_MAGIC:   exp_magic      = value;
            CFG_VERSION: exp_version    = value[31:0];
            CFG_MAXSIZE: exp_size_limit = value[POS_W-1:0];
            default: ;
        endcase
    endtask

    // Upper data bits above each register's width are random: they must be
    // dropped. A write to the unmapped index must change nothing.
    task automatic program_registers(input logic [63:0] magic, input logic [31:0] version,
                                     input logic [POS_W-1:0] limit);
        write_register(CFG_MAGIC, magic);
        write_register(CFG_VERSION, {32'($urandom), version});
        write_register(CFG_UNMAPPED, {$urandom, $urandom});
        write_register(CFG_MAXSIZE, {5'($urandom), 32'($urandom), limit});
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every byte went in and every verdict came out, then let the
    // pipeline settle so the block is idle before the next register write.
    task automatic wait_until_drained();
        while (pending_bytes.size() != 0 || pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random traffic under the current registers. Mostly well-formed
    // containers (half of them damaged in one spot), the rest pure noise.
    task automatic run_phase(input bit stall_receiver, input int unsigned byte_budget);
        int unsigned start_bytes;
        int unsigned start_frames;
        int unsigned pick;
        t_defect     flaw;
        @(posedge i_clk);
        start_bytes  = bytes_queued;
        start_frames = containers_queued;
        if (stall_receiver)
            holdoff_request = 1'b1;
        while (bytes_queued - start_bytes < byte_budget ||
               containers_queued - start_frames < 4) begin
            pick = $urandom_range(9, 0);
            if (pick < 7) begin
                if ($urandom_range(1, 0) == 0)
                    flaw = DEFECT_NONE;
                else
                    flaw = t_defect'($urandom_range(int'(DEFECT_TRUNCATE), int'(DEFECT_MAGIC)));
                queue_container(exp_magic, exp_version,
                                (pick == 6) ? $urandom_range(100, 30) : $urandom_range(16, 0),
                                flaw);
            end else begin
                queue_noise($urandom_range(40, 1));
            end
        end
        wait_until_drained();
    endtask

    // ------------------------------------------------------------------------
    // Driver: offers the head of pending_bytes at the falling edge. Bursts of
    // random length alternate with random gaps; a third of the gaps are zero,
    // so long back-to-back stretches happen too. An offered byte is held
    // until the block takes it.
    // ------------------------------------------------------------------------
    int unsigned burst_left = 8;
    int unsigned gap_left   = 0;

    always @(negedge i_clk) begin
        bit offer;
        offer = 1'b0;
        if (i_rst_n) begin
            if (byte_taken) begin
                byte_taken = 1'b0;
                pending_bytes.delete(0);
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(24, 1);
                    gap_left   = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(8, 1);
                end
                offer = (gap_left == 0) && (pending_bytes.size() != 0);
            end else if (push) begin
                offer = 1'b1;              // blocked by full: keep the same transaction
            end else if (gap_left > 0) begin
                gap_left--;
            end else begin
                offer = (pending_bytes.size() != 0);
            end
        end
        push <= offer;
        if (offer) begin
            i_data_byte <= pending_bytes[0].data;
            i_last_byte <= pending_bytes[0].last;
        end else begin
            // junk on the data lines while push is low must be ignored
            i_data_byte <= 8'($urandom);
            i_last_byte <= 1'($urandom);
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: its own pace pattern, switched at random intervals, plus a
    // long hold-off on request so the result buffer and byte queue fill and
    // full rises while the driver keeps offering.
    // ------------------------------------------------------------------------
    t_rx_pace    rx_pace      = PACE_STEADY;
    int unsigned pace_left    = 0;
    int unsigned holdoff_left = 0;

    always @(negedge i_clk) begin
        if (holdoff_request) begin
            holdoff_request = 1'b0;
            holdoff_left    = HOLDOFF_CYCLES;
        end
        if (pace_left == 0) begin
            rx_pace   = t_rx_pace'($urandom_range(int'(PACE_SPARSE), int'(PACE_STEADY)));
            pace_left = $urandom_range(80, 10);
        end else begin
            pace_left--;
        end
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (holdoff_left > 0) begin
            holdoff_left--;
            pop <= 1'b0;
        end else begin
            case (rx_pace)
                PACE_STEADY: pop <= 1'b1;
                PACE_HALF:   pop <= 1'($urandom);
                default:     pop <= ($urandom_range(3, 0) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Monitor at the rising edge: predicts on every accepted byte, checks
    // every popped verdict against the oldest prediction, and runs the
    // watchdog on cycles where no transaction of any kind completes.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result verdict;
        t_result wanted;
        bit      progress;
        progress = 1'b0;
        if (i_rst_n) begin
            if (push && !full) begin
                progress   = 1'b1;
                byte_taken = 1'b1;
                if (track_container_byte(i_data_byte, i_last_byte, verdict))
                    pending_verdicts.insert(pending_verdicts.size(), verdict);
            end
            if (push && full)
                backpressure_cycles++;

            if (pop && !empty) begin
                progress = 1'b1;
                if (pending_verdicts.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected verdict: status %0d hash %h payload %0d",
                             $time, o_status, o_computed_hash, o_payload_bytes);
                end else begin
                    wanted = pending_verdicts.pop_front();
                    verdicts_checked++;
                    verdict_tally[wanted.status]++;
                    if (o_status !== wanted.status) begin
                        mismatch_count++;
                        $display("%0t: status expected %0d, actual %0d",
                                 $time, wanted.status, o_status);
                    end
                    if (o_computed_hash !== wanted.hash) begin
                        mismatch_count++;
                        $display("%0t: computed_hash expected %h, actual %h",
                                 $time, wanted.hash, o_computed_hash);
                    end
                    if (o_payload_bytes !== wanted.payload) begin
                        mismatch_count++;
                        $display("%0t: payload_bytes expected %0d, actual %0d",
                                 $time, wanted.payload, o_payload_bytes);
                    end
                end
            end

            if (i_cfg_valid && o_cfg_ready)
                progress = 1'b1;
            idle_cycles = progress ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired, %0d bytes and %0d verdicts outstanding",
                         $time, pending_bytes.size(), pending_verdicts.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        exp_magic      = '0;
        exp_version    = 32'd2;
        exp_size_limit = SIZE_LIMIT_TOP;
        clear_tracking();

        // synchronous reset, released at a falling edge, never asserted again
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset values of the registers: short containers, an
        // empty payload, a small payload, each header field damaged, and a
        // container cut off partway.
        @(posedge i_clk);
        queue_noise(1);
        queue_noise(27);
        queue_container(exp_magic, exp_version, 0, DEFECT_NONE);
        queue_container(exp_magic, exp_version, 1, DEFECT_NONE);
        queue_container(exp_magic, exp_version, 2, DEFECT_MAGIC);
        queue_container(exp_magic, exp_version, 2, DEFECT_VERSION);
        queue_container(exp_magic, exp_version, 2, DEFECT_LENGTH);
        queue_container(exp_magic, exp_version, 2, DEFECT_CHECKSUM);
        queue_container(exp_magic, exp_version, 5, DEFECT_TRUNCATE);
        wait_until_drained();

        // Limit at the header size: a bare header passes, one more byte fails.
        program_registers('1, 32'hFFFF_FFFF, POS_W'(HDR_BYTES));
        @(posedge i_clk);
        queue_container(exp_magic, exp_version, 0, DEFECT_NONE);
        queue_container(exp_magic, exp_version, 1, DEFECT_NONE);
        queue_container(exp_magic, exp_version, 0, DEFECT_MAGIC);
        wait_until_drained();

        // Limit below the header size: every container is rejected on size.
        program_registers({$urandom, $urandom}, 32'd0, POS_W'(10));
        @(posedge i_clk);
        queue_container(exp_magic, exp_version, 0, DEFECT_NONE);
        queue_noise(10);
        queue_noise(11);
        wait_until_drained();

        // Random phases over several settings, two of them with a long
        // receiver hold-off to force back-pressure on the input.
        program_registers({$urandom, $urandom}, 32'($urandom), SIZE_LIMIT_TOP);
        run_phase(1'b1, 160);
        program_registers({$urandom, $urandom}, 32'($urandom), POS_W'(60));
        run_phase(1'b0, 160);
        program_registers('0, 32'd2, POS_W'($urandom_range(200, 28)));
        run_phase(1'b1, 160);
        program_registers({$urandom, $urandom}, 32'($urandom), SIZE_LIMIT_TOP);
        run_phase(1'b0, 160);

        $display("Ran %0d containers, %0d bytes, seven register setups, %0d full cycles.",
                 verdicts_checked, bytes_queued, backpressure_cycles);
        $display("Verdicts: ok %0d, size %0d, magic %0d, version %0d, length %0d, checksum %0d.",
                 verdict_tally[ST_OK], verdict_tally[ST_BAD_SIZE], verdict_tally[ST_BAD_MAGIC],
                 verdict_tally[ST_BAD_VER], verdict_tally[ST_BAD_LEN], verdict_tally[ST_BAD_SUM]);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
